/* rtl/core/thermal_packet_pec_checker_defines.svh */
// Assertion macros shared by the packet checker RTL.
`ifndef THERMAL_PACKET_PEC_CHECKER_DEFINES_SVH
`define THERMAL_PACKET_PEC_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS
// Assertion on an explicit clock and active-low reset.
`define TPC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assertion on the default clock and reset of the block.
`define TPC_ASSERT(lbl, prop, msg) \
  `TPC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define TPC_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define TPC_ASSERT(lbl, prop, msg)
`endif

`endif

/* rtl/core/tpc_pkg.sv */
// Types, constants and CRC helpers for the packet PEC checker.
package tpc_pkg;

  localparam int unsigned MaxWords = 32;
  localparam int unsigned IdxW     = $clog2(MaxWords);
  localparam int unsigned WordCntW = 6;
  localparam int unsigned PosW     = 7;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [7:0] CrcPoly = 8'h07;
  localparam logic [7:0] CrcTop  = 8'h80;

  localparam logic [WordCntW-1:0] WordCountReset = 6'd17;
  localparam logic [7:0]          SeedReset      = 8'h15;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgWordCount = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSeedByte  = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } pkt_in_t;

  typedef struct packed {
    logic [15:0]     sample_value;
    logic [IdxW-1:0] sample_index;
    logic            pec_ok;
    logic [7:0]      computed_crc;
    logic            last;
  } result_t;

  // Load request into the shared CRC unit.
  typedef struct packed {
    logic       load;
    logic [7:0] value;
  } crc_ctrl_t;

  // Write port of the word buffer.
  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    logic [15:0]     data;
  } wbuf_wr_t;

  // One bit step of the MSB-first CRC-8.
  function automatic logic [7:0] crc_bit_step(logic [7:0] v);
    logic [7:0] shifted;
    shifted = {v[6:0], 1'b0};
    return ((v & CrcTop) != 8'h00) ? (shifted ^ CrcPoly) : shifted;
  endfunction

  // Full byte fold, used only for constants.
  function automatic logic [7:0] crc_fold(logic [7:0] crc, logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      v = crc_bit_step(v);
    end
    return v;
  endfunction

  localparam logic [7:0] CrcReset = crc_fold(8'h00, SeedReset);

  // Word count clamped to the legal range of one up to the buffer depth.
  function automatic logic [WordCntW-1:0] eff_words(logic [WordCntW-1:0] wc);
    logic [WordCntW-1:0] n;
    n = wc;
    if (n == '0) begin
      n = WordCntW'(1);
    end else if (n > WordCntW'(MaxWords)) begin
      n = WordCntW'(MaxWords);
    end
    return n;
  endfunction

endpackage

/* rtl/core/thermal_packet_pec_checker.sv */
// Top level of the packet PEC checker: sequencer, configuration and result registers.
//
// Usage: drive pkt_i and raise start while busy is low; that edge accepts one
// byte transaction. busy stays high while the byte is processed. The CRC-8 is
// folded by one shared shift unit at one bit per clock, and a byte flagged
// packet_start first waits for the seed fold. After the PEC byte of a packet of
// N words, N results leave on consecutive cycles, one word read from the buffer
// each cycle, and the seed fold for the next packet follows. A PEC mismatch
// gives one failure result, followed by the seed fold. Results appear on res_o
// for one cycle, marked by result_valid_o; the receiver cannot stall them.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 word_count, 1 seed_byte) at once. The user must write only while busy is
// low; the block itself does not enforce it. A new seed is used from the next
// packet start or end of packet.
// Reset is asynchronous: both registers take their defaults, the CRC holds the
// fold of the default seed and the byte position returns to zero.
`include "thermal_packet_pec_checker_defines.svh"

module thermal_packet_pec_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  tpc_pkg::pkt_in_t               pkt_i,
  output logic                           result_valid_o,
  output tpc_pkg::result_t               res_o,
  input  logic                           cfg_we_i,
  input  logic [tpc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [7:0]                     cfg_data_i
);

  typedef enum logic [2:0] {
    StIdle,
    StSeedStart,
    StCheck,
    StFold,
    StDrain,
    StSeedEnd
  } state_e;

  state_e state_q;

  logic [tpc_pkg::WordCntW-1:0] word_count_q;
  logic [7:0]                   seed_q;
  logic [7:0]                   crc_acc_q;
  logic [tpc_pkg::PosW-1:0]     pos_q;
  logic [7:0]                   low_q;
  logic [7:0]                   byte_q;
  logic [tpc_pkg::IdxW-1:0]     rd_idx_q;
  logic [tpc_pkg::IdxW-1:0]     last_idx_q;
  tpc_pkg::wbuf_wr_t            wr_q;

  logic                         out_valid_q;
  logic                         out_ok_q;
  logic                         out_last_q;
  logic [tpc_pkg::IdxW-1:0]     out_idx_q;
  logic [7:0]                   out_crc_q;

  tpc_pkg::crc_ctrl_t           crc_ctrl;
  logic [7:0]                   crc_val;
  logic                         crc_done;
  logic [15:0]                  rd_data;
  logic                         rd_en;
  logic [tpc_pkg::WordCntW-1:0] words;
  logic [tpc_pkg::PosW-1:0]     pos_limit;
  logic                         accept;

  assign accept    = start && !busy;
  assign words     = tpc_pkg::eff_words(word_count_q);
  assign pos_limit = {1'b0, words};
  assign rd_en     = (state_q == StDrain);

  // Load requests into the shared CRC unit.
  always_comb begin
    crc_ctrl = '0;
    case (state_q)
      StIdle: begin
        if (accept && pkt_i.packet_start) begin
          crc_ctrl.load  = 1'b1;
          crc_ctrl.value = seed_q;
        end
      end
      StCheck: begin
        crc_ctrl.load = 1'b1;
        if (pos_q < (pos_limit << 1)) begin
          crc_ctrl.value = crc_acc_q ^ byte_q;
        end else begin
          // On a match the reseed waits until the drain ends.
          crc_ctrl.load  = (crc_acc_q != byte_q);
          crc_ctrl.value = seed_q;
        end
      end
      StDrain: begin
        if (rd_idx_q == last_idx_q) begin
          crc_ctrl.load  = 1'b1;
          crc_ctrl.value = seed_q;
        end
      end
      default: begin
        crc_ctrl = '0;
      end
    endcase
  end

  tpc_crc_unit u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .crc_o  (crc_val),
    .done_o (crc_done)
  );

  tpc_word_buf u_buf (
    .clk_i     (clk_i),
    .wr_i      (wr_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (rd_data)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q <= tpc_pkg::WordCountReset;
      seed_q       <= tpc_pkg::SeedReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tpc_pkg::CfgWordCount: word_count_q <= cfg_data_i[tpc_pkg::WordCntW-1:0];
        tpc_pkg::CfgSeedByte:  seed_q       <= cfg_data_i;
        default: begin
          seed_q <= seed_q;
        end
      endcase
    end
  end

  // Sequencer with packet state and registered result fields.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      crc_acc_q   <= tpc_pkg::CrcReset;
      pos_q       <= '0;
      low_q       <= '0;
      byte_q      <= '0;
      wr_q        <= '0;
      out_valid_q <= 1'b0;
      out_ok_q    <= 1'b0;
      out_last_q  <= 1'b0;
      out_idx_q   <= '0;
      out_crc_q   <= '0;
      rd_idx_q    <= '0;
      last_idx_q  <= '0;
    end else begin
      out_valid_q <= 1'b0;
      wr_q.en     <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            byte_q  <= pkt_i.data_byte;
            state_q <= pkt_i.packet_start ? StSeedStart : StCheck;
          end
        end
        StSeedStart: begin
          if (crc_done) begin
            crc_acc_q <= crc_val;
            pos_q     <= '0;
            low_q     <= '0;
            state_q   <= StCheck;
          end
        end
        StCheck: begin
          if (pos_q < (pos_limit << 1)) begin
            // Data byte: pair it into a word and fold it into the CRC.
            if (!pos_q[0]) begin
              low_q <= byte_q;
            end else begin
              wr_q.en   <= 1'b1;
              wr_q.addr <= pos_q[tpc_pkg::IdxW:1];
              wr_q.data <= {byte_q, low_q};
            end
            pos_q   <= pos_q + tpc_pkg::PosW'(1);
            state_q <= StFold;
          end else if (crc_acc_q == byte_q) begin
            // PEC byte matches: drain the stored words.
            rd_idx_q   <= '0;
            last_idx_q <= tpc_pkg::IdxW'(words - tpc_pkg::WordCntW'(1));
            out_crc_q  <= crc_acc_q;
            state_q    <= StDrain;
          end else begin
            // PEC byte mismatch: one failure transaction.
            out_valid_q <= 1'b1;
            out_ok_q    <= 1'b0;
            out_last_q  <= 1'b1;
            out_idx_q   <= '0;
            out_crc_q   <= crc_acc_q;
            state_q     <= StSeedEnd;
          end
        end
        StFold: begin
          if (crc_done) begin
            crc_acc_q <= crc_val;
            state_q   <= StIdle;
          end
        end
        StDrain: begin
          out_valid_q <= 1'b1;
          out_ok_q    <= 1'b1;
          out_idx_q   <= rd_idx_q;
          out_last_q  <= (rd_idx_q == last_idx_q);
          rd_idx_q    <= rd_idx_q + tpc_pkg::IdxW'(1);
          if (rd_idx_q == last_idx_q) begin
            state_q <= StSeedEnd;
          end
        end
        StSeedEnd: begin
          if (crc_done) begin
            crc_acc_q <= crc_val;
            pos_q     <= '0;
            low_q     <= '0;
            state_q   <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Result ports.
  assign busy                = (state_q != StIdle);
  assign result_valid_o      = out_valid_q;
  assign res_o.sample_value  = out_ok_q ? rd_data : 16'h0000;
  assign res_o.sample_index  = out_idx_q;
  assign res_o.pec_ok        = out_ok_q;
  assign res_o.computed_crc  = out_crc_q;
  assign res_o.last          = out_last_q;

  // Results only come out of a packet end that is still being worked on.
  `TPC_ASSERT(a_result_while_busy, result_valid_o |-> busy, "result outside of a busy period")
  // The final result of a packet is followed by the reseed, never another result.
  `TPC_ASSERT(a_last_then_quiet, (result_valid_o && res_o.last) |=> !result_valid_o, "result after last")
  // An accepted transaction always makes the block busy in the next cycle.
  `TPC_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted transaction not taken up")

endmodule

/* rtl/core/tpc_crc_unit.sv */
// Shared bit-serial CRC-8 unit: folds one bit per clock.
module tpc_crc_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tpc_pkg::crc_ctrl_t    ctrl_i,
  output logic [7:0]            crc_o,
  output logic                  done_o
);

  logic [7:0] shift_q, shift_d;
  logic [2:0] cnt_q, cnt_d;
  logic       run_q, run_d;
  logic       done_q, done_d;

  // Load, then step the shift register once per clock until eight steps are done.
  always_comb begin
    shift_d = shift_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    done_d  = 1'b0;
    if (ctrl_i.load) begin
      shift_d = ctrl_i.value;
      cnt_d   = '0;
      run_d   = 1'b1;
    end else if (run_q) begin
      shift_d = tpc_pkg::crc_bit_step(shift_q);
      cnt_d   = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  assign crc_o  = shift_q;
  assign done_o = done_q;

endmodule

/* rtl/core/tpc_word_buf.sv */
// Word buffer: one write port and one registered read port.
module tpc_word_buf (
  input  logic                          clk_i,
  input  tpc_pkg::wbuf_wr_t             wr_i,
  input  logic                          rd_en_i,
  input  logic [tpc_pkg::IdxW-1:0]      rd_addr_i,
  output logic [15:0]                   rd_data_o
);

  logic [15:0] mem_q [tpc_pkg::MaxWords];
  logic [15:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
